FILE: rtl/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants for the sentence boundary splitter
// Byte codes, register indexes, widths and the result record type.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int unsigned POS_W     = 25;
  localparam int unsigned NUM_W     = 24;
  localparam int unsigned SPAN_W    = 14;
  localparam int unsigned SKIP_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 14;

  // Offsets saturate here (one past the largest byte index).
  localparam logic [POS_W-1:0]  POS_MAX  = 25'd16777216;
  localparam logic [SPAN_W-1:0] SPAN_MAX = 14'd16383;

  localparam logic [SPAN_W-1:0] SEARCH_LIMIT_RST = 14'd10000;
  localparam logic [SKIP_W-1:0] SKIP_LIMIT_RST   = 7'd100;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LIMIT   = 1'b1;

  // Byte codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_E3    = 8'hE3;
  localparam logic [7:0] CH_80    = 8'h80;
  localparam logic [7:0] CH_82    = 8'h82;
  localparam logic [7:0] CH_EF    = 8'hEF;
  localparam logic [7:0] CH_BC    = 8'hBC;
  localparam logic [7:0] CH_9F    = 8'h9F;
  localparam logic [7:0] CH_81    = 8'h81;

  typedef struct packed {
    logic [POS_W-1:0] sentence_start;
    logic [POS_W-1:0] sentence_end;
    logic [NUM_W-1:0] sentence_number;
    logic [POS_W-1:0] trimmed_start;
    logic [POS_W-1:0] trimmed_end;
  } sbs_result_t;

  // Third byte of a full-width period, question mark or exclamation mark
  function automatic logic closes_mark(input logic [15:0] prev2, input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    if (prev2[15:8] == CH_E3 && prev2[7:0] == CH_80 && b == CH_82) begin
      hit = 1'b1;
    end
    if (prev2[15:8] == CH_EF && prev2[7:0] == CH_BC && (b == CH_9F || b == CH_81)) begin
      hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

FILE: rtl/sbs_out_skid.sv
// ----------------------------------------------------------------------------
// sbs_out_skid: two-entry result buffer
// Output register plus one skid entry so the input side keeps moving while
// a result beat waits on a stalled receiver.
// ----------------------------------------------------------------------------
module sbs_out_skid
  import sbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sbs_result_t push_data,
  input  logic        out_stall,
  output logic        out_valid,
  output sbs_result_t out_data,
  output logic        full
);

  logic        out_valid_r, out_valid_nxt;
  sbs_result_t out_data_r, out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  sbs_result_t skid_data_r, skid_data_nxt;
  logic        pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      // advance: skid entry first, else the new beat
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      // hold the output, park the new beat
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = skid_valid_r;

endmodule

FILE: rtl/sentence_boundary_splitter_unit.sv
// ----------------------------------------------------------------------------
// sentence_boundary_splitter_unit: UTF-8 sentence splitter
// Scans one text byte per beat and emits trimmed sentence offsets.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while in_stall is low.
// A result beat is registered in the output buffer from the byte that ends it.
// The scan state is registered from each accepted byte; a two-entry
// output buffer absorbs result stalls, in_stall rises only when both are full.
// Reset (synchronous, rst_n low): scan state cleared, search_limit = 10000,
// skip_limit = 100, output buffer empty.
module sentence_boundary_splitter_unit
  import sbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  // input bytes
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_final_byte,
  // result beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_W-1:0]     out_sentence_start,
  output logic [POS_W-1:0]     out_sentence_end,
  output logic [NUM_W-1:0]     out_sentence_number,
  output logic [POS_W-1:0]     out_trimmed_start,
  output logic [POS_W-1:0]     out_trimmed_end
);

  // Configuration registers
  logic [SPAN_W-1:0] search_limit_r;
  logic [SKIP_W-1:0] skip_limit_r;

  // Scan state
  logic [POS_W-1:0]  byte_pos_r,   byte_pos_nxt;
  logic [POS_W-1:0]  sent_begin_r, sent_begin_nxt;
  logic [NUM_W-1:0]  sent_cnt_r,   sent_cnt_nxt;
  logic [POS_W-1:0]  first_vis_r,  first_vis_nxt;
  logic              has_vis_r,    has_vis_nxt;
  logic [POS_W-1:0]  last_vis_r,   last_vis_nxt;
  logic [15:0]       recent_r,     recent_nxt;
  logic [SPAN_W-1:0] span_r,       span_nxt;
  logic              to_end_r,     to_end_nxt;
  logic              skip_mode_r,  skip_mode_nxt;
  logic [SKIP_W-1:0] skip_cnt_r,   skip_cnt_nxt;

  logic              accept;
  logic [POS_W-1:0]  pos_next;
  logic              is_ws;
  logic              consumed;
  logic              boundary;
  logic              ended;
  logic              emit;
  sbs_result_t       res;
  sbs_result_t       buf_data;
  logic              buf_full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = buf_full;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_limit_r <= SEARCH_LIMIT_RST;
      skip_limit_r   <= SKIP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEARCH_LIMIT: search_limit_r <= cfg_wdata;
        CFG_SKIP_LIMIT:   skip_limit_r   <= cfg_wdata[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset just past this byte, saturating at the text bound
  assign pos_next = (byte_pos_r >= POS_MAX) ? POS_MAX : byte_pos_r + 1'b1;
  assign is_ws    = (in_text_byte == CH_SPACE) || (in_text_byte == CH_TAB) ||
                    (in_text_byte == CH_CR);

  always_comb begin
    byte_pos_nxt   = pos_next;
    sent_begin_nxt = sent_begin_r;
    sent_cnt_nxt   = sent_cnt_r;
    first_vis_nxt  = first_vis_r;
    has_vis_nxt    = has_vis_r;
    last_vis_nxt   = last_vis_r;
    span_nxt       = span_r;
    to_end_nxt     = to_end_r;
    skip_mode_nxt  = skip_mode_r;
    skip_cnt_nxt   = skip_cnt_r;
    recent_nxt     = {recent_r[7:0], in_text_byte};
    consumed       = 1'b0;
    boundary       = 1'b0;
    ended          = 1'b0;
    emit           = 1'b0;
    res            = '0;

    // Whitespace skip after a boundary: drop the byte while within the limit,
    // otherwise open a fresh sentence at this byte.
    if (skip_mode_r) begin
      if (is_ws && skip_cnt_r < skip_limit_r) begin
        skip_cnt_nxt   = skip_cnt_r + 1'b1;
        sent_begin_nxt = pos_next;
        consumed       = 1'b1;
      end else begin
        skip_mode_nxt  = 1'b0;
        sent_begin_nxt = byte_pos_r;
        has_vis_nxt    = 1'b0;
        first_vis_nxt  = byte_pos_r;
        last_vis_nxt   = byte_pos_r;
        span_nxt       = '0;
        to_end_nxt     = 1'b0;
      end
    end

    if (!consumed) begin
      if (span_nxt < SPAN_MAX) begin
        span_nxt = span_nxt + 1'b1;
      end
      // Track the trim window: first and last visible bytes
      if (!is_ws && !has_vis_nxt) begin
        has_vis_nxt   = 1'b1;
        first_vis_nxt = byte_pos_r;
      end
      if (!is_ws && in_text_byte != CH_LF) begin
        last_vis_nxt = pos_next;
      end
      boundary = !to_end_nxt &&
                 (in_text_byte == CH_LF || in_text_byte == CH_TAB ||
                  (span_nxt >= SPAN_W'(3) && closes_mark(recent_r, in_text_byte)));
      if (in_final_byte) begin
        ended = 1'b1;
      end else if (!to_end_nxt) begin
        if (boundary && span_nxt < search_limit_r) begin
          ended         = 1'b1;
          skip_mode_nxt = 1'b1;
          skip_cnt_nxt  = '0;
        end else if (span_nxt >= search_limit_r) begin
          // long sentence: run to the end of the text
          to_end_nxt = 1'b1;
        end
      end
      if (ended) begin
        emit                = has_vis_nxt && (last_vis_nxt > first_vis_nxt);
        res.sentence_start  = sent_begin_nxt;
        res.sentence_end    = pos_next;
        res.sentence_number = sent_cnt_r;
        res.trimmed_start   = first_vis_nxt;
        res.trimmed_end     = last_vis_nxt;
        sent_cnt_nxt        = sent_cnt_r + 1'b1;
        sent_begin_nxt      = pos_next;
        has_vis_nxt         = 1'b0;
        first_vis_nxt       = pos_next;
        last_vis_nxt        = pos_next;
        span_nxt            = '0;
        to_end_nxt          = 1'b0;
      end
    end

    // End of text: clear the scan state for the next text
    if (in_final_byte) begin
      byte_pos_nxt   = '0;
      sent_begin_nxt = '0;
      sent_cnt_nxt   = '0;
      first_vis_nxt  = '0;
      has_vis_nxt    = 1'b0;
      last_vis_nxt   = '0;
      recent_nxt     = '0;
      span_nxt       = '0;
      to_end_nxt     = 1'b0;
      skip_mode_nxt  = 1'b0;
      skip_cnt_nxt   = '0;
    end
  end

  // Advance the scan state on every accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      sent_begin_r <= '0;
      sent_cnt_r   <= '0;
      first_vis_r  <= '0;
      has_vis_r    <= 1'b0;
      last_vis_r   <= '0;
      recent_r     <= '0;
      span_r       <= '0;
      to_end_r     <= 1'b0;
      skip_mode_r  <= 1'b0;
      skip_cnt_r   <= '0;
    end else if (accept) begin
      byte_pos_r   <= byte_pos_nxt;
      sent_begin_r <= sent_begin_nxt;
      sent_cnt_r   <= sent_cnt_nxt;
      first_vis_r  <= first_vis_nxt;
      has_vis_r    <= has_vis_nxt;
      last_vis_r   <= last_vis_nxt;
      recent_r     <= recent_nxt;
      span_r       <= span_nxt;
      to_end_r     <= to_end_nxt;
      skip_mode_r  <= skip_mode_nxt;
      skip_cnt_r   <= skip_cnt_nxt;
    end
  end

  // Result buffer: output register plus skid entry
  sbs_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && emit),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (buf_data),
    .full      (buf_full)
  );

  assign out_sentence_start  = buf_data.sentence_start;
  assign out_sentence_end    = buf_data.sentence_end;
  assign out_sentence_number = buf_data.sentence_number;
  assign out_trimmed_start   = buf_data.trimmed_start;
  assign out_trimmed_end     = buf_data.trimmed_end;

endmodule
